// ===== design/srlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srlp_pkg;

  // Parser phases (plain state codes).
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_TYPE     = 3'd1;
  localparam logic [2:0] PH_LENGTH   = 3'd2;
  localparam logic [2:0] PH_ADDRESS  = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_CHECKSUM = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_TYPE    = 3'd0;
  localparam logic [2:0] KIND_LENGTH  = 3'd1;
  localparam logic [2:0] KIND_ADDRESS = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_STATUS  = 3'd4;

  // Record status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_S    = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_BAD_SUM  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TYPE_MASK  = 2'd0;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd1;
  localparam logic [1:0] CFG_SUM_TARGET = 2'd2;

  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam int unsigned DefAddressBytes = 2;

  typedef struct packed {
    logic [2:0] phase;
    logic [3:0] high_nibble;
    logic       nibble_pending;
    logic [7:0] running_sum;
    logic [7:0] record_length;
    logic [7:0] byte_counter;
  } parse_state_t;

  typedef struct packed {
    logic [9:0] type_enable_mask;
    logic [7:0] max_length;
    logic [7:0] checksum_target;
  } parse_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] field_kind;
    logic [7:0] field_value;
    logic [7:0] byte_index;
    logic [2:0] status;
    logic       last;
  } parse_result_t;

  // Characters outside 0-9, A-F and a-f decode as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/srecord_line_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// S-record line parser. Characters of record text enter on the input channel
// (in_valid_i / in_stall_o) with record_start_i marking the leading 'S'.
// Decoded items leave on the output channel (out_valid_o / out_stall_i):
// the type digit, the length byte, each address and data byte with its
// index, and one closing status request with last_o set.
// A character is captured in an input register at the edge that accepts it,
// and its result, if it has one, is written to the output register once that
// register is free or being emptied. Unless the receiver stalls, one
// character per cycle is sustained; the decode, the byte sum and the phase
// update sit in one combinational pass between those two registers.
// When the receiver stalls, the output register holds its request and the
// input register can still take one more character; only then does
// in_stall_o rise. Reset clears the phase to idle, the byte sum and the
// counters, and loads the configuration defaults: type mask 0x207,
// maximum length 255 and checksum target 255.
// Configuration writes through cfg_we_i, cfg_index_i and cfg_data_i take
// effect at the next edge and should only be issued while the parser idles.
module srecord_line_parser_core #(
  parameter int unsigned ADDRESS_BYTES = srlp_pkg::DefAddressBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       record_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] field_kind_o,
  output logic [7:0] field_value_o,
  output logic [7:0] byte_index_o,
  output logic [2:0] status_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);
  import srlp_pkg::*;

  parse_cfg_t    cfg_q;
  parse_state_t  state_q, state_d;
  parse_result_t result_d;
  parse_result_t out_q;

  logic       in_vld_q;
  logic [7:0] char_q;
  logic       start_q;
  logic       in_accept;
  logic       proceed;

  // The held character moves on whenever the output register is free or
  // is being emptied in this cycle.
  assign proceed    = in_vld_q && (!out_q.valid || !out_stall_i);
  assign in_stall_o = in_vld_q && !proceed;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_enable_mask <= 10'd519;
      cfg_q.max_length       <= 8'd255;
      cfg_q.checksum_target  <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TYPE_MASK:  cfg_q.type_enable_mask <= cfg_data_i;
        CFG_MAX_LENGTH: cfg_q.max_length       <= cfg_data_i[7:0];
        CFG_SUM_TARGET: cfg_q.checksum_target  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (proceed) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q  <= char_code_i;
      start_q <= record_start_i;
    end
  end

  srlp_step #(
    .ADDRESS_BYTES(ADDRESS_BYTES)
  ) u_step (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .char_code_i    (char_q),
    .record_start_i (start_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (proceed) begin
      state_q <= state_d;
    end
  end

  // Output register. The valid bit is the only control bit; payload simply
  // follows whenever a new result is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      if (proceed) begin
        out_q.valid <= result_d.valid;
      end else if (!out_stall_i) begin
        out_q.valid <= 1'b0;
      end
      if (proceed && result_d.valid) begin
        out_q.field_kind  <= result_d.field_kind;
        out_q.field_value <= result_d.field_value;
        out_q.byte_index  <= result_d.byte_index;
        out_q.status      <= result_d.status;
        out_q.last        <= result_d.last;
      end
    end
  end

  assign out_valid_o   = out_q.valid;
  assign field_kind_o  = out_q.field_kind;
  assign field_value_o = out_q.field_value;
  assign byte_index_o  = out_q.byte_index;
  assign status_o      = out_q.status;
  assign last_o        = out_q.last;

`ifndef SYNTH
  // A finished record or the idle parser never holds half a byte.
  a_idle_no_nibble : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE) |-> !state_q.nibble_pending)
    else $error("idle parser holds a pending nibble");

  // The address index always stays inside the address field.
  a_addr_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_ADDRESS) |-> ({1'b0, state_q.byte_counter} < 9'(ADDRESS_BYTES)))
    else $error("address byte counter out of range");

  // Only the status request closes a record, and only it carries a status.
  a_last_is_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((last_o == (field_kind_o == KIND_STATUS)) &&
                     (last_o || (status_o == ST_OK))))
    else $error("last flag or status does not match the result kind");

  // A character waiting for a full output register must not leave the input stage.
  a_hold_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_q.valid && out_stall_i) |=> (in_vld_q && $stable(state_q)))
    else $error("parser advanced while the output was blocked");
`endif

endmodule

`default_nettype wire

// ===== design/srlp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srlp_step #(
  parameter int unsigned ADDRESS_BYTES = srlp_pkg::DefAddressBytes
) (
  input  srlp_pkg::parse_state_t  state_i,
  input  srlp_pkg::parse_cfg_t    cfg_i,
  input  logic [7:0]              char_code_i,
  input  logic                    record_start_i,
  output srlp_pkg::parse_state_t  state_o,
  output srlp_pkg::parse_result_t result_o
);
  import srlp_pkg::*;

  localparam logic [8:0] AddrBytes9  = 9'(ADDRESS_BYTES);
  localparam logic [9:0] AddrBytes10 = 10'(ADDRESS_BYTES);

  logic       is_digit;
  logic       type_ok;
  logic [7:0] byte_val;
  logic [7:0] sum_next;
  logic [7:0] cnt_next;
  logic       has_data;
  logic       addr_done;
  logic       data_done;

  always_comb begin
    is_digit  = (char_code_i >= CHAR_0) && (char_code_i <= CHAR_9);
    type_ok   = is_digit ? cfg_i.type_enable_mask[char_code_i[3:0]] : 1'b0;
    byte_val  = {state_i.high_nibble, hex_value(char_code_i)};
    sum_next  = state_i.running_sum + byte_val;
    cnt_next  = state_i.byte_counter + 8'd1;
    // Data bytes exist when the length exceeds address plus checksum bytes.
    has_data  = {1'b0, state_i.record_length} > (AddrBytes9 + 9'd1);
    addr_done = {1'b0, cnt_next} >= AddrBytes9;
    data_done = ({2'b00, cnt_next} + AddrBytes10 + 10'd1) >= {2'b00, state_i.record_length};
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;

    if (record_start_i) begin
      state_o.high_nibble    = 4'd0;
      state_o.nibble_pending = 1'b0;
      state_o.running_sum    = 8'd0;
      state_o.record_length  = 8'd0;
      state_o.byte_counter   = 8'd0;
      if (char_code_i != CHAR_S) begin
        state_o.phase        = PH_IDLE;
        result_o.valid       = 1'b1;
        result_o.field_kind  = KIND_STATUS;
        result_o.field_value = char_code_i;
        result_o.status      = ST_NOT_S;
        result_o.last        = 1'b1;
      end else begin
        state_o.phase = PH_TYPE;
      end
    end else if (state_i.phase == PH_IDLE) begin
      state_o = state_i;
    end else if (state_i.phase == PH_TYPE) begin
      result_o.valid = 1'b1;
      if (!type_ok) begin
        state_o.phase          = PH_IDLE;
        state_o.nibble_pending = 1'b0;
        result_o.field_kind    = KIND_STATUS;
        result_o.field_value   = char_code_i;
        result_o.status        = ST_BAD_TYPE;
        result_o.last          = 1'b1;
      end else begin
        state_o.phase        = PH_LENGTH;
        result_o.field_kind  = KIND_TYPE;
        result_o.field_value = {4'd0, char_code_i[3:0]};
      end
    end else if (!state_i.nibble_pending) begin
      state_o.high_nibble    = hex_value(char_code_i);
      state_o.nibble_pending = 1'b1;
    end else begin
      state_o.nibble_pending = 1'b0;
      state_o.running_sum    = sum_next;
      result_o.valid         = 1'b1;
      result_o.field_value   = byte_val;
      unique case (state_i.phase)
        PH_LENGTH: begin
          if (byte_val > cfg_i.max_length) begin
            state_o.phase       = PH_IDLE;
            result_o.field_kind = KIND_STATUS;
            result_o.status     = ST_TOO_LONG;
            result_o.last       = 1'b1;
          end else begin
            state_o.record_length = byte_val;
            state_o.byte_counter  = 8'd0;
            state_o.phase         = PH_ADDRESS;
            result_o.field_kind   = KIND_LENGTH;
          end
        end
        PH_ADDRESS: begin
          result_o.field_kind = KIND_ADDRESS;
          result_o.byte_index = state_i.byte_counter;
          state_o.byte_counter = cnt_next;
          if (addr_done) begin
            state_o.byte_counter = 8'd0;
            state_o.phase        = has_data ? PH_DATA : PH_CHECKSUM;
          end
        end
        PH_DATA: begin
          result_o.field_kind = KIND_DATA;
          result_o.byte_index = state_i.byte_counter;
          state_o.byte_counter = cnt_next;
          if (data_done) begin
            state_o.byte_counter = 8'd0;
            state_o.phase        = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          state_o.phase       = PH_IDLE;
          result_o.field_kind = KIND_STATUS;
          result_o.status     = (sum_next == cfg_i.checksum_target) ? ST_OK : ST_BAD_SUM;
          result_o.last       = 1'b1;
        end
        default: begin
          state_o.phase  = PH_IDLE;
          result_o.valid = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/srecord_line_parser_core_tb.sv =====
`timescale 1ns / 1ps

module srecord_line_parser_core_tb;
  import srlp_pkg::*;

  // The block is built with its default address field width.
  localparam int AddrBytes  = DefAddressBytes;
  // Minimum count of record characters offered in each random configuration phase.
  localparam int PhaseChars = 250;
  localparam int NumPhases  = 8;
  // Length of the one long receiver hold-off, in cycles.
  localparam int LongHold   = 400;

  // One decoded field as it leaves the parser.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] index;
    logic [2:0] status;
    logic       last;
  } parse_item_t;

  // One character of record text together with its start flag.
  typedef struct packed {
    logic [7:0] code;
    logic       start;
  } text_char_t;

  typedef enum logic {ROW_CHAR, ROW_WRITE} row_op_e;

  // A row of the directed table: either a character, optionally with the
  // field it must produce written out by hand, or a register write.
  typedef struct packed {
    row_op_e     op;
    logic [7:0]  code;
    logic        start;
    logic        typed;
    parse_item_t want;
    logic [1:0]  reg_index;
    logic [9:0]  reg_data;
  } stim_row_t;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] char_code    = 8'h00;
  logic       record_start = 1'b0;
  logic       out_stall    = 1'b0;
  logic       cfg_we       = 1'b0;
  logic [1:0] cfg_index    = CFG_TYPE_MASK;
  logic [9:0] cfg_data     = 10'h000;

  logic       in_stall;
  logic       out_valid;
  logic [2:0] res_kind;
  logic [7:0] res_value;
  logic [7:0] res_index;
  logic [2:0] res_status;
  logic       res_last;

  // Hand-written expectation that travels alongside the character on the
  // input channel; when set it replaces the predicted field.
  logic        row_typed  = 1'b0;
  parse_item_t row_expect = '0;

  // Fields predicted for accepted characters, oldest first.
  parse_item_t fields_due[$];
  int          mismatches = 0;

  // Knobs shared between the stimulus flow and the receiver process.
  bit sender_gaps    = 1'b1;
  bit receiver_gaps  = 1'b1;
  bit hold_requested = 1'b0;

  // Predicted parser state and register contents.
  logic [2:0] prs_phase;
  logic [3:0] prs_hi;
  logic       prs_hi_pending;
  logic [7:0] prs_sum;
  logic [7:0] prs_len;
  logic [7:0] prs_pos;
  logic [9:0] type_mask_m;
  logic [7:0] len_limit_m;
  logic [7:0] sum_goal_m;

  // Register values as the stimulus generator knows them; kept in the main
  // flow so that generation never races with the predictor's update.
  logic [9:0] gen_mask  = 10'h207;
  logic [7:0] gen_limit = 8'hFF;
  logic [7:0] gen_goal  = 8'hFF;

  stim_row_t  dir_rows[$];
  text_char_t text_q[$];

  srecord_line_parser_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_code_i    (char_code),
    .record_start_i (record_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .field_kind_o   (res_kind),
    .field_value_o  (res_value),
    .byte_index_o   (res_index),
    .status_o       (res_status),
    .last_o         (res_last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run must never take this long, even with every stall at its worst.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Returns {is_hex, digit value}; anything that is not a hex digit reads
  // as zero, which is how the parser treats it.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    logic       ok;
    ok = 1'b1;
    t  = 8'h00;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      t = c - CHAR_0;
    end else if (c >= "A" && c <= "F") begin
      t = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      t = c - "a" + 8'd10;
    end else begin
      ok = 1'b0;
    end
    return {ok, t[3:0]};
  endfunction

  function automatic int data_bytes(input logic [7:0] len);
    int n;
    n = int'(len);
    n = n - AddrBytes - 1;
    return (n > 0) ? n : 0;
  endfunction

  function automatic parse_item_t mk_item(input logic [2:0] kind, input logic [7:0] value,
                                          input logic [7:0] index, input logic [2:0] status,
                                          input logic last);
    parse_item_t it;
    it.kind   = kind;
    it.value  = value;
    it.index  = index;
    it.status = status;
    it.last   = last;
    return it;
  endfunction

  // Advances the predicted parser by one accepted character and reports the
  // field it produces, if any.
  task automatic decode_char(input logic [7:0] c, input logic s, output bit hit,
                             output parse_item_t item);
    logic [4:0] dig;
    logic [7:0] b;
    hit  = 1'b0;
    item = '0;
    if (s) begin
      // A start flag always throws away whatever record was in progress.
      prs_hi         = 4'd0;
      prs_hi_pending = 1'b0;
      prs_sum        = 8'd0;
      prs_len        = 8'd0;
      prs_pos        = 8'd0;
      if (c == CHAR_S) begin
        prs_phase = PH_TYPE;
      end else begin
        prs_phase = PH_IDLE;
        hit       = 1'b1;
        item      = mk_item(KIND_STATUS, c, 8'd0, ST_NOT_S, 1'b1);
      end
    end else if (prs_phase == PH_TYPE) begin
      b   = c - CHAR_0;
      hit = 1'b1;
      if (c >= CHAR_0 && c <= CHAR_9 && type_mask_m[b[3:0]]) begin
        prs_phase = PH_LENGTH;
        item      = mk_item(KIND_TYPE, b, 8'd0, ST_OK, 1'b0);
      end else begin
        prs_phase      = PH_IDLE;
        prs_hi_pending = 1'b0;
        item           = mk_item(KIND_STATUS, c, 8'd0, ST_BAD_TYPE, 1'b1);
      end
    end else if (prs_phase != PH_IDLE) begin
      dig = hex_digit(c);
      if (!prs_hi_pending) begin
        prs_hi         = dig[3:0];
        prs_hi_pending = 1'b1;
      end else begin
        prs_hi_pending = 1'b0;
        b              = {prs_hi, dig[3:0]};
        prs_sum        = prs_sum + b;
        hit            = 1'b1;
        case (prs_phase)
          PH_LENGTH: begin
            if (b > len_limit_m) begin
              prs_phase = PH_IDLE;
              item      = mk_item(KIND_STATUS, b, 8'd0, ST_TOO_LONG, 1'b1);
            end else begin
              prs_len   = b;
              prs_pos   = 8'd0;
              prs_phase = PH_ADDRESS;
              item      = mk_item(KIND_LENGTH, b, 8'd0, ST_OK, 1'b0);
            end
          end
          PH_ADDRESS: begin
            item    = mk_item(KIND_ADDRESS, b, prs_pos, ST_OK, 1'b0);
            prs_pos = prs_pos + 8'd1;
            if (int'(prs_pos) >= AddrBytes) begin
              prs_pos   = 8'd0;
              prs_phase = (data_bytes(prs_len) > 0) ? PH_DATA : PH_CHECKSUM;
            end
          end
          PH_DATA: begin
            item    = mk_item(KIND_DATA, b, prs_pos, ST_OK, 1'b0);
            prs_pos = prs_pos + 8'd1;
            if (int'(prs_pos) >= data_bytes(prs_len)) begin
              prs_pos   = 8'd0;
              prs_phase = PH_CHECKSUM;
            end
          end
          PH_CHECKSUM: begin
            prs_phase = PH_IDLE;
            item      = mk_item(KIND_STATUS, b, 8'd0,
                                (prs_sum == sum_goal_m) ? ST_OK : ST_BAD_SUM, 1'b1);
          end
          default: begin
            prs_phase = PH_IDLE;
            hit       = 1'b0;
          end
        endcase
      end
    end
  endtask

  // Input side: mirror register writes and predict each accepted request.
  // Everything here is sampled at the edge, before the block updates.
  always @(posedge clk) begin : accept_side
    bit          hit;
    parse_item_t pred;
    if (!rst_n) begin
      prs_phase      = PH_IDLE;
      prs_hi         = 4'd0;
      prs_hi_pending = 1'b0;
      prs_sum        = 8'd0;
      prs_len        = 8'd0;
      prs_pos        = 8'd0;
      type_mask_m    = 10'h207;
      len_limit_m    = 8'hFF;
      sum_goal_m     = 8'hFF;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TYPE_MASK:  type_mask_m = cfg_data;
          CFG_MAX_LENGTH: len_limit_m = cfg_data[7:0];
          CFG_SUM_TARGET: sum_goal_m  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        decode_char(char_code, record_start, hit, pred);
        if (row_typed) begin
          fields_due.push_back(row_expect);
        end else if (hit) begin
          fields_due.push_back(pred);
        end
      end
    end
  end

  // Output side: every accepted request must match the oldest prediction.
  always @(posedge clk) begin : result_side
    parse_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fields_due.size() == 0) begin
        $error("unexpected result: kind %0d value %h index %0d status %0d last %0d",
               res_kind, res_value, res_index, res_status, res_last);
        mismatches++;
      end else begin
        want = fields_due.pop_front();
        if (res_kind !== want.kind) begin
          $error("field_kind: expected %0d, got %0d", want.kind, res_kind);
          mismatches++;
        end
        if (res_value !== want.value) begin
          $error("field_value: expected %h, got %h", want.value, res_value);
          mismatches++;
        end
        if (res_index !== want.index) begin
          $error("byte_index: expected %0d, got %0d", want.index, res_index);
          mismatches++;
        end
        if (res_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_status);
          mismatches++;
        end
        if (res_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res_last);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request that
  // lets the parser fill up and push back on its input.
  initial begin : receiver
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requested) begin
        hold_requested = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Offers one character and returns at the edge that accepts it. The
  // payload holds steady for as long as the parser stalls it.
  task automatic send_char(input logic [7:0] c, input logic s, input logic typed,
                           input parse_item_t want);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    record_start <= s;
    row_typed    <= typed;
    row_expect   <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted field has come out. The
  // parser may still hold a character that yields nothing, so the task keeps
  // idling afterwards to let such a character drain from the input register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fields_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_TYPE_MASK:  gen_mask  = val;
      CFG_MAX_LENGTH: gen_limit = val[7:0];
      CFG_SUM_TARGET: gen_goal  = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_char(input logic [7:0] c, input logic s);
    stim_row_t r;
    r       = '0;
    r.op    = ROW_CHAR;
    r.code  = c;
    r.start = s;
    dir_rows.push_back(r);
  endtask

  task automatic add_expect(input logic [7:0] c, input logic s, input logic [2:0] kind,
                            input logic [7:0] value, input logic [7:0] index,
                            input logic [2:0] status, input logic last);
    stim_row_t r;
    r       = '0;
    r.op    = ROW_CHAR;
    r.code  = c;
    r.start = s;
    r.typed = 1'b1;
    r.want  = mk_item(kind, value, index, status, last);
    dir_rows.push_back(r);
  endtask

  task automatic add_write(input logic [1:0] idx, input logic [9:0] val);
    stim_row_t r;
    r           = '0;
    r.op        = ROW_WRITE;
    r.reg_index = idx;
    r.reg_data  = val;
    dir_rows.push_back(r);
  endtask

  // Text for one nibble: upper or lower case at random, and now and then a
  // zero nibble spelled as some non-hex character, which decodes to zero.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    logic [4:0] d;
    if (n == 4'd0 && $urandom_range(0, 29) == 0) begin
      c = 8'h00;
      d = 5'h10;
      while (d[4]) begin
        c = 8'($urandom_range(0, 255));
        d = hex_digit(c);
      end
    end else if (n < 4'd10) begin
      c = CHAR_0 + {4'd0, n};
    end else begin
      c = ($urandom_range(0, 1) ? "a" : "A") + {4'd0, n} - 8'd10;
    end
    return c;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic s);
    text_char_t t;
    t.code  = c;
    t.start = s;
    text_q.push_back(t);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_char(hex_char(b[7:4]), 1'b0);
    push_char(hex_char(b[3:0]), 1'b0);
  endtask

  // Builds one record into text_q. Most records are well formed with random
  // content and a matching checksum; the rest carry a wrong start character,
  // a rejected type, an oversized length, a bad checksum or a cut-off tail.
  task automatic build_record(inout int used);
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] ck;
    text_char_t dropped;
    int         r;
    int         nd;
    int         cut;
    bit         go;
    text_q.delete();
    go = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      push_char(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      push_char(CHAR_S, 1'b1);
      if ($urandom_range(0, 6) == 0) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        d = 8'($urandom_range(0, 9));
        while (gen_mask != 10'h000 && !gen_mask[d[3:0]]) d = 8'($urandom_range(0, 9));
        c = CHAR_0 + d;
      end
      push_char(c, 1'b0);
      d  = c - CHAR_0;
      go = (c >= CHAR_0 && c <= CHAR_9) && gen_mask[d[3:0]];
    end
    if (go) begin
      // Mostly short records; long ones are rare since each costs hundreds
      // of characters.
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = 8'($urandom_range(0, (gen_limit < 8'd12) ? gen_limit : 12));
      end else if (r < 88 || gen_limit == 8'hFF) begin
        len = 8'($urandom_range(0, gen_limit));
      end else begin
        len = 8'($urandom_range(gen_limit + 1, 255));
      end
      push_byte(len);
      sum = len;
      if (len <= gen_limit) begin
        nd = data_bytes(len);
        repeat (AddrBytes + nd) begin
          c = 8'($urandom_range(0, 255));
          push_byte(c);
          sum = sum + c;
        end
        ck = gen_goal - sum;
        if ($urandom_range(0, 4) == 0) ck = ck ^ 8'($urandom_range(1, 255));
        push_byte(ck);
      end
    end
    // A record cut short is left hanging; the next start flag abandons it.
    cut = 0;
    if (text_q.size() > 2 && $urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, text_q.size() - 2);
      repeat (cut) dropped = text_q.pop_back();
    end
    used += text_q.size();
    // Stray text after a finished record is ignored by the parser and does
    // not count toward the phase budget.
    if (cut == 0 && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin : main_flow
    stim_row_t  row;
    text_char_t ch;
    int         used;
    int         p;

    // Directed table, run with the reset register values (types 0, 1, 2
    // and 9 enabled, length limit 255, checksum target 255).
    // A start character other than 'S', here the lowest code.
    add_expect(8'h00, 1'b1, KIND_STATUS, 8'h00, 8'd0, ST_NOT_S, 1'b1);
    // Idle text is ignored; the highest code.
    add_char(8'hFF, 1'b0);
    // A digit whose type is disabled, then a character that is no digit.
    add_char(CHAR_S, 1'b1);
    add_expect("3", 1'b0, KIND_STATUS, "3", 8'd0, ST_BAD_TYPE, 1'b1);
    add_char(CHAR_S, 1'b1);
    add_expect(":", 1'b0, KIND_STATUS, ":", 8'd0, ST_BAD_TYPE, 1'b1);
    // A record abandoned halfway through its length byte by a new start.
    add_char(CHAR_S, 1'b1);
    add_expect(CHAR_9, 1'b0, KIND_TYPE, 8'd9, 8'd0, ST_OK, 1'b0);
    add_char("7", 1'b0);
    // A short record: length 3 leaves no data bytes. The second address
    // byte is spelled with a NUL, which reads as zero. The checksum is off.
    add_char(CHAR_S, 1'b1);
    add_expect("1", 1'b0, KIND_TYPE, 8'd1, 8'd0, ST_OK, 1'b0);
    add_char(CHAR_0, 1'b0);
    add_expect("3", 1'b0, KIND_LENGTH, 8'h03, 8'd0, ST_OK, 1'b0);
    add_char("F", 1'b0);
    add_expect("f", 1'b0, KIND_ADDRESS, 8'hFF, 8'd0, ST_OK, 1'b0);
    add_char(8'h00, 1'b0);
    add_expect(CHAR_0, 1'b0, KIND_ADDRESS, 8'h00, 8'd1, ST_OK, 1'b0);
    add_char("F", 1'b0);
    add_expect("E", 1'b0, KIND_STATUS, 8'hFE, 8'd0, ST_BAD_SUM, 1'b1);
    // With a lower length limit, a length byte of 0x20 is rejected.
    add_write(CFG_MAX_LENGTH, 10'h010);
    add_char(CHAR_S, 1'b1);
    add_char("1", 1'b0);
    add_char("2", 1'b0);
    add_expect(CHAR_0, 1'b0, KIND_STATUS, 8'h20, 8'd0, ST_TOO_LONG, 1'b1);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.op == ROW_WRITE) begin
        settle();
        write_reg(row.reg_index, row.reg_data);
        cfg_we <= 1'b0;
      end else begin
        send_char(row.code, row.start, row.typed, row.want);
      end
    end

    // Random phases, each under its own register setting. The extremes come
    // first; the last phase runs with no idling on either side.
    for (p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(CFG_TYPE_MASK, 10'h3FF);
          write_reg(CFG_MAX_LENGTH, 10'h0FF);
          write_reg(CFG_SUM_TARGET, 10'h000);
        end
        1: begin
          write_reg(CFG_TYPE_MASK, 10'h000);
          write_reg(CFG_MAX_LENGTH, 10'h0FF);
          write_reg(CFG_SUM_TARGET, 10'h0FF);
        end
        2: begin
          write_reg(CFG_TYPE_MASK, 10'($urandom_range(0, 1023)) | 10'h001);
          write_reg(CFG_MAX_LENGTH, 10'h000);
          write_reg(CFG_SUM_TARGET, 10'($urandom_range(0, 255)));
        end
        3: begin
          write_reg(CFG_TYPE_MASK, 10'h3FF);
          write_reg(CFG_MAX_LENGTH, 10'h003);
          write_reg(CFG_SUM_TARGET, 10'($urandom_range(0, 255)));
        end
        default: begin
          write_reg(CFG_TYPE_MASK, 10'($urandom_range(0, 1023)));
          write_reg(CFG_MAX_LENGTH,
                    $urandom_range(0, 1) ? 10'($urandom_range(3, 20))
                                         : 10'($urandom_range(0, 255)));
          write_reg(CFG_SUM_TARGET, 10'($urandom_range(0, 255)));
        end
      endcase
      cfg_we <= 1'b0;

      sender_gaps   = (p != 2) && (p != 3) && (p != NumPhases - 1);
      receiver_gaps = (p != 4) && (p != NumPhases - 1);
      // In this phase the sender offers back to back while the receiver
      // holds off for a long stretch, so the input side must stall.
      if (p == 3) hold_requested = 1'b1;

      used = 0;
      while (used < PhaseChars) begin
        build_record(used);
        while (text_q.size() > 0) begin
          ch = text_q.pop_front();
          send_char(ch.code, ch.start, 1'b0, '0);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
